@@ sv/u2u8_pkg.sv @@
// Shared types, constants and the code point to UTF-8 byte function.
package u2u8_pkg;

   localparam logic [15:0] SurHighFirst = 16'hD800;
   localparam logic [15:0] SurHighLast  = 16'hDBFF;
   localparam logic [15:0] SurLowFirst  = 16'hDC00;
   localparam logic [15:0] SurLowLast   = 16'hDFFF;
   localparam logic [20:0] SupplBase    = 21'h10000;
   localparam logic [20:0] Max1Byte     = 21'h0007F;
   localparam logic [20:0] Max2Byte     = 21'h007FF;
   localparam logic [20:0] Max3Byte     = 21'h0FFFF;
   localparam logic [7:0]  Lead2        = 8'hC0;
   localparam logic [7:0]  Lead3        = 8'hE0;
   localparam logic [7:0]  Lead4        = 8'hF0;
   localparam logic [7:0]  ContMark     = 8'h80;

   localparam int MaxBytes = 6;
   localparam int CntW     = $clog2(MaxBytes + 1);

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
      logic        wide_units;
   } item_type;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CntW-1:0]          cnt;
      logic                     eos;
   } group_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      cnt;
   } cp_bytes_type;

   function automatic cp_bytes_type encode_cp(input logic [20:0] cp);
      cp_bytes_type r;
      r = '0;
      if (cp <= Max1Byte) begin
         r.bytes[0] = cp[7:0];
         r.cnt      = 3'd1;
      end else if (cp <= Max2Byte) begin
         r.bytes[0] = Lead2 | {3'b000, cp[10:6]};
         r.bytes[1] = ContMark | {2'b00, cp[5:0]};
         r.cnt      = 3'd2;
      end else if (cp <= Max3Byte) begin
         r.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
         r.bytes[1] = ContMark | {2'b00, cp[11:6]};
         r.bytes[2] = ContMark | {2'b00, cp[5:0]};
         r.cnt      = 3'd3;
      end else begin
         r.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
         r.bytes[1] = ContMark | {2'b00, cp[17:12]};
         r.bytes[2] = ContMark | {2'b00, cp[11:6]};
         r.bytes[3] = ContMark | {2'b00, cp[5:0]};
         r.cnt      = 3'd4;
      end
      return r;
   endfunction

endpackage

@@ sv/u2u8_encode.sv @@
// Combinational encoder: one code unit plus held surrogate into a byte group.
module u2u8_encode (
   input  u2u8_pkg::item_type  item,
   input  logic                held_valid,
   input  logic [9:0]          held_high_bits,
   output u2u8_pkg::group_type grp,
   output logic                nxt_held_valid,
   output logic [9:0]          nxt_held_high_bits
);
   import u2u8_pkg::*;

   logic         is_high;
   logic         is_low;
   logic         pair;
   logic         prefix;
   logic         hold_new;
   logic [20:0]  cp_main;
   logic [15:0]  held_unit;
   cp_bytes_type pre_enc;
   cp_bytes_type cp_enc;
   logic [3:0][7:0] main_bytes;
   logic [2:0]      main_cnt;

   assign is_high  = (item.code_unit >= SurHighFirst) && (item.code_unit <= SurHighLast);
   assign is_low   = (item.code_unit >= SurLowFirst) && (item.code_unit <= SurLowLast);
   assign pair     = held_valid && item.wide_units && is_low;
   assign prefix   = held_valid && !pair;
   assign hold_new = item.wide_units && !pair && is_high && !item.end_of_string;

   assign held_unit = SurHighFirst + {6'b000000, held_high_bits};
   assign cp_main   = pair ? SupplBase + {1'b0, held_high_bits, item.code_unit[9:0]}
                           : {5'b00000, item.code_unit};

   assign pre_enc = encode_cp({5'b00000, held_unit});
   assign cp_enc  = encode_cp(cp_main);

   always_comb begin
      main_bytes = '0;
      main_cnt   = 3'd0;
      if (!item.wide_units) begin
         main_bytes[0] = item.code_unit[7:0];
         main_cnt      = 3'd1;
      end else if (!hold_new) begin
         main_bytes = cp_enc.bytes;
         main_cnt   = cp_enc.cnt;
      end
   end

   always_comb begin
      grp       = '0;
      grp.eos   = item.end_of_string;
      if (prefix) begin
         grp.bytes[0] = pre_enc.bytes[0];
         grp.bytes[1] = pre_enc.bytes[1];
         grp.bytes[2] = pre_enc.bytes[2];
         grp.bytes[3] = main_bytes[0];
         grp.bytes[4] = main_bytes[1];
         grp.bytes[5] = main_bytes[2];
         grp.cnt      = CntW'(3) + CntW'(main_cnt);
      end else begin
         grp.bytes[0] = main_bytes[0];
         grp.bytes[1] = main_bytes[1];
         grp.bytes[2] = main_bytes[2];
         grp.bytes[3] = main_bytes[3];
         grp.cnt      = CntW'(main_cnt);
      end
   end

   assign nxt_held_valid     = hold_new;
   assign nxt_held_high_bits = hold_new ? item.code_unit[9:0] : 10'd0;

endmodule

@@ sv/u2u8_serializer.sv @@
// Result register for one byte group, sent one byte per transfer.
module u2u8_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  u2u8_pkg::group_type load_grp,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_string_done
);
   import u2u8_pkg::*;

   group_type       grp_ff, grp_in;
   logic            valid_ff, valid_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic            xfer;
   logic            at_last;

   assign at_last    = (idx_ff == grp_ff.cnt - CntW'(1));
   assign xfer       = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (xfer && at_last);

   always_comb begin
      grp_in   = grp_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load_ready) begin
         // take the next group, or drain empty
         valid_in = load_valid;
         idx_in   = '0;
         if (load_valid) begin
            grp_in = load_grp;
         end
      end else if (xfer) begin
         idx_in = idx_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      grp_ff <= grp_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = grp_ff.bytes[idx_ff[2:0]];
   assign rsp_run_last    = at_last;
   assign rsp_string_done = at_last && grp_ff.eos;

endmodule

@@ sv/utf16_to_utf8_transcoder.sv @@
// Top level: input register, surrogate state, encoder and byte serializer.
// A unit in the input register is encoded and loaded into the serializer, whose
// result port sends one byte per transfer; a unit yields 0 to 6 bytes, and the
// next unit waits in the input register while those bytes go out.
// Reset clears the valid flags and the held high surrogate; payload is not reset.
module utf16_to_utf8_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_string,
   input  logic        req_wide_units,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_done
);
   import u2u8_pkg::*;

   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_high_bits_ff, held_high_bits_in;
   group_type  enc_grp;
   logic       enc_held_valid;
   logic [9:0] enc_held_bits;
   logic       load_ready;
   logic       item_move;
   logic       req_xfer;

   assign item_move = item_valid_ff && load_ready;
   assign req_stall = item_valid_ff && !load_ready;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      item_in           = item_ff;
      item_valid_in     = item_valid_ff && !item_move;
      held_valid_in     = held_valid_ff;
      held_high_bits_in = held_high_bits_ff;
      if (req_xfer) begin
         item_in       = '{code_unit: req_code_unit, end_of_string: req_end_of_string,
                           wide_units: req_wide_units};
         item_valid_in = 1'b1;
      end
      if (item_move) begin
         held_valid_in     = enc_held_valid;
         held_high_bits_in = enc_held_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         held_valid_ff     <= 1'b0;
         held_high_bits_ff <= '0;
      end else begin
         item_valid_ff     <= item_valid_in;
         held_valid_ff     <= held_valid_in;
         held_high_bits_ff <= held_high_bits_in;
      end
      item_ff <= item_in;
   end

   u2u8_encode u_encode (
      .item               (item_ff),
      .held_valid         (held_valid_ff),
      .held_high_bits     (held_high_bits_ff),
      .grp                (enc_grp),
      .nxt_held_valid     (enc_held_valid),
      .nxt_held_high_bits (enc_held_bits)
   );

   u2u8_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (item_valid_ff && (enc_grp.cnt != '0)),
      .load_grp        (enc_grp),
      .load_ready      (load_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   a_eos_clears_held: assert property (@(posedge clock) disable iff (reset)
      (item_move && item_ff.end_of_string) |=> !held_valid_ff)
      else $error("surrogate still held after end of string");

   a_narrow_clears_held: assert property (@(posedge clock) disable iff (reset)
      (item_move && !item_ff.wide_units) |=> !held_valid_ff)
      else $error("surrogate still held after narrow unit");

   a_group_loads: assert property (@(posedge clock) disable iff (reset)
      (item_move && enc_grp.cnt != '0) |=> rsp_valid)
      else $error("byte group lost on load");

endmodule

@@ test/utf16_to_utf8_transcoder_tb.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
module utf16_to_utf8_transcoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u2u8_pkg::*;

   localparam int FromPredictor = -1;
   localparam int RandomItems   = 155;
   localparam int DrainCycles   = 20;
   localparam int CycleLimit    = 200000;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        eos;
      logic        wide;
      int          nbytes;
      logic [47:0] bytes;
   } dir_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       run_last;
      logic       string_done;
   } utf8_beat_type;

   typedef enum int {
      KAscii, KTwoByte, KThreeByte, KPair, KLoneHigh, KLoneLow, KAnyUnit, KNarrow
   } unit_kind_type;

   // typed rows list their bytes first to last; FromPredictor rows are computed
   localparam dir_row_type DirRows [25] = '{
      '{16'h0000, 1'b0, 1'b0, 1, 48'h00},
      '{16'hFFFF, 1'b1, 1'b0, 1, 48'hFF},
      '{16'h0000, 1'b0, 1'b1, 1, 48'h00},
      '{16'h007F, 1'b0, 1'b1, 1, 48'h7F},
      '{16'h0080, 1'b0, 1'b1, 2, 48'hC280},
      '{16'h07FF, 1'b0, 1'b1, 2, 48'hDFBF},
      '{16'h0800, 1'b0, 1'b1, 3, 48'hE0A080},
      '{16'hFFFF, 1'b1, 1'b1, 3, 48'hEFBFBF},
      '{16'hD800, 1'b0, 1'b1, 0, 48'h0},
      '{16'hDC00, 1'b1, 1'b1, 4, 48'hF0908080},
      '{16'hDBFF, 1'b0, 1'b1, 0, 48'h0},
      '{16'hDFFF, 1'b0, 1'b1, 4, 48'hF48FBFBF},
      '{16'hD800, 1'b1, 1'b1, 3, 48'hEDA080},
      '{16'hDC00, 1'b0, 1'b1, 3, 48'hEDB080},
      '{16'hDFFF, 1'b0, 1'b1, 3, 48'hEDBFBF},
      '{16'hE000, 1'b1, 1'b1, 3, 48'hEE8080},
      '{16'hD801, 1'b0, 1'b1, 0, 48'h0},
      '{16'h0041, 1'b0, 1'b1, 4, 48'hEDA08141},
      '{16'hDBFF, 1'b0, 1'b1, FromPredictor, 48'h0},
      '{16'hD800, 1'b0, 1'b1, FromPredictor, 48'h0},
      '{16'h125A, 1'b0, 1'b0, FromPredictor, 48'h0},
      '{16'hD9AB, 1'b0, 1'b1, FromPredictor, 48'h0},
      '{16'hDBCD, 1'b1, 1'b1, FromPredictor, 48'h0},
      '{16'hD83D, 1'b0, 1'b1, FromPredictor, 48'h0},
      '{16'hDE00, 1'b1, 1'b1, FromPredictor, 48'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit = '0;
   logic        req_end_of_string = 1'b0;
   logic        req_wide_units = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_done;

   // typed expectation that travels with the payload
   int          tab_len = FromPredictor;
   logic [47:0] tab_bytes = '0;

   int gap_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;

   logic          held_valid = 1'b0;
   logic [9:0]    held_bits = '0;
   logic [7:0]    unit_utf8 [$];
   utf8_beat_type utf8_due [$];

   utf16_to_utf8_transcoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .req_wide_units  (req_wide_units),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void put_code_point(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         unit_utf8.push_back(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         unit_utf8.push_back({3'b110, cp[10:6]});
         unit_utf8.push_back({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         unit_utf8.push_back({4'b1110, cp[15:12]});
         unit_utf8.push_back({2'b10, cp[11:6]});
         unit_utf8.push_back({2'b10, cp[5:0]});
      end else begin
         unit_utf8.push_back({5'b11110, cp[20:18]});
         unit_utf8.push_back({2'b10, cp[17:12]});
         unit_utf8.push_back({2'b10, cp[11:6]});
         unit_utf8.push_back({2'b10, cp[5:0]});
      end
   endfunction

   // Advance the surrogate state by one unit and leave its bytes in unit_utf8.
   function automatic void transcode_unit(input logic [15:0] cu, input logic eos,
                                          input logic wide);
      logic is_high;
      logic is_low;
      logic paired;
      is_high = cu >= SurHighFirst && cu <= SurHighLast;
      is_low  = cu >= SurLowFirst && cu <= SurLowLast;
      paired  = 1'b0;
      unit_utf8.delete();
      if (held_valid) begin
         if (wide && is_low) begin
            put_code_point(SupplBase + {1'b0, held_bits, cu[9:0]});
            paired = 1'b1;
         end else begin
            put_code_point({5'b0, SurHighFirst[15:10], held_bits});
         end
         held_valid = 1'b0;
         held_bits  = '0;
      end
      if (!wide) begin
         unit_utf8.push_back(cu[7:0]);
      end else if (!paired) begin
         if (is_high && !eos) begin
            held_valid = 1'b1;
            held_bits  = cu[9:0];
         end else begin
            put_code_point({5'b0, cu});
         end
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      utf8_beat_type want;
      int n;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (utf8_due.size() == 0) begin
               flag_mismatch($sformatf("byte %02h with nothing due", rsp_out_byte));
            end else begin
               want = utf8_due.pop_front();
               if (rsp_out_byte !== want.value || rsp_run_last !== want.run_last ||
                   rsp_string_done !== want.string_done) begin
                  flag_mismatch($sformatf("got %02h last %b done %b, due %02h last %b done %b",
                     rsp_out_byte, rsp_run_last, rsp_string_done,
                     want.value, want.run_last, want.string_done));
               end
            end
         end
         if (req_valid && !req_stall) begin
            transcode_unit(req_code_unit, req_end_of_string, req_wide_units);
            if (tab_len != FromPredictor) begin
               unit_utf8.delete();
               for (int i = 0; i < tab_len; i++) begin
                  unit_utf8.push_back(tab_bytes[8*(tab_len-1-i) +: 8]);
               end
            end
            n = unit_utf8.size();
            for (int i = 0; i < n; i++) begin
               utf8_due.push_back('{unit_utf8[i], i == n-1, i == n-1 && req_end_of_string});
            end
         end
      end
   end

   initial begin : rsp_backpressure
      int hold;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("** utf16_to_utf8_transcoder: FAILED **");
      $finish;
   end

   // Present one unit and hold it until the transfer.
   task automatic send_unit(input logic [15:0] cu, input logic eos, input logic wide,
                            input int nbytes, input logic [47:0] bytes);
      int gap;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_code_unit     <= cu;
      req_end_of_string <= eos;
      req_wide_units    <= wide;
      tab_len           <= nbytes;
      tab_bytes         <= bytes;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin : stimulus
      logic [16:0]   word_q [$];
      logic          wide_str;
      logic [15:0]   high_unit;
      int            len;
      int            sent;
      logic          drained;
      unit_kind_type kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      gap_pct   = 20;
      stall_pct = 20;
      foreach (DirRows[r]) begin
         send_unit(DirRows[r].code_unit, DirRows[r].eos, DirRows[r].wide,
                   DirRows[r].nbytes, DirRows[r].bytes);
      end
      sent    = 0;
      drained = 1'b0;
      while (sent < RandomItems) begin
         if (sent >= RandomItems - 30) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            gap_pct   = 20 * $urandom_range(0, 2);
            stall_pct = 20 * $urandom_range(0, 2);
         end
         if (!drained && sent >= RandomItems / 2) begin
            // hold off until every due byte has come out
            req_valid <= 1'b0;
            @(posedge clock);
            while (utf8_due.size() != 0) @(posedge clock);
            drained = 1'b1;
         end
         word_q.delete();
         wide_str = $urandom_range(0, 6) != 0;
         len = $urandom_range(1, 8);
         while (word_q.size() < len) begin
            if (!wide_str) begin
               word_q.push_back({1'b0, 16'($urandom)});
            end else begin
               kind = $urandom_range(0, 1) ? KPair
                                           : unit_kind_type'($urandom_range(0, int'(KNarrow)));
               high_unit = 16'($urandom_range(int'(SurHighFirst), int'(SurHighLast)));
               case (kind)
                  KAscii: word_q.push_back({1'b1, 16'($urandom_range(0, 'h7F))});
                  KTwoByte: word_q.push_back({1'b1, 16'($urandom_range('h80, 'h7FF))});
                  KThreeByte: begin
                     if ($urandom_range(0, 1)) begin
                        word_q.push_back({1'b1, 16'($urandom_range('h800, 'hD7FF))});
                     end else begin
                        word_q.push_back({1'b1, 16'($urandom_range('hE000, 'hFFFF))});
                     end
                  end
                  KPair: begin
                     word_q.push_back({1'b1, high_unit});
                     word_q.push_back({1'b1,
                        16'($urandom_range(int'(SurLowFirst), int'(SurLowLast)))});
                  end
                  KLoneHigh: word_q.push_back({1'b1, high_unit});
                  KLoneLow: word_q.push_back({1'b1,
                     16'($urandom_range(int'(SurLowFirst), int'(SurLowLast)))});
                  KAnyUnit: word_q.push_back({1'b1, 16'($urandom)});
                  default: word_q.push_back({1'b0, 16'($urandom)});
               endcase
            end
         end
         for (int k = 0; k < word_q.size(); k++) begin
            send_unit(word_q[k][15:0], k == word_q.size() - 1, word_q[k][16],
                      FromPredictor, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (utf8_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && utf8_due.size() == 0) begin
         $display("** utf16_to_utf8_transcoder: PASSED **");
      end else begin
         $display("** utf16_to_utf8_transcoder: FAILED **");
      end
      $finish;
   end

endmodule
